/* rtl/hce_pkg.sv */
// Shared constants, types and a helper function for the Hamming code encoder.
`default_nettype none

package hce_pkg;

	localparam int MSG_W            = 57;
	localparam int CW_W             = 63;
	localparam int CW_IW            = 6;
	localparam int LEN_W            = 6;
	localparam int PC_W             = 3;
	localparam int NPAR             = 6;
	localparam int MAX_MSG_BITS_DEF = 57;
	localparam int MSG_LEN_RST      = 57;

	// Parity partial sums are formed over groups of this many codeword bits.
	localparam int GRP_W = 16;
	localparam int NGRP  = (CW_W + GRP_W - 1) / GRP_W;

	// Control that travels alongside a codeword through the pipeline.
	typedef struct packed {
		logic             vld;
		logic [LEN_W-1:0] code_len;
		logic [PC_W-1:0]  parity_count;
	} hce_ctl_t;

	// Zero-based codeword bit that holds message bit k: the k-th position,
	// counting from one, that is not a power of two.
	function automatic int data_pos(input int k);
		int cnt;
		int res;
		cnt = 0;
		res = 0;
		for (int pos = 1; pos <= CW_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				if (cnt == k) begin
					res = pos - 1;
				end
				cnt++;
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/hce_parity.sv */
// Parity stages of the Hamming code encoder: partial XOR sums, then final parity insertion.
`default_nettype none

module hce_parity
	import hce_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  hce_ctl_t        src_ctl,
	input  logic [CW_W-1:0] src_word,
	output hce_ctl_t        res_ctl,
	output logic [CW_W-1:0] res_word
);

	logic [NGRP-1:0] par_d [NPAR];
	logic [NGRP-1:0] par_s2 [NPAR];
	logic [CW_W-1:0] word_s2;
	hce_ctl_t        ctl_s2;
	logic [CW_W-1:0] word_d;
	logic [CW_W-1:0] word_s3;
	hce_ctl_t        ctl_s3;

	// Each parity bit covers the positions whose index has its bit set; the
	// coverage is split into groups so the XOR depth per stage stays even.
	always_comb begin
		for (int k = 0; k < NPAR; k++) begin
			for (int g = 0; g < NGRP; g++) begin
				par_d[k][g] = 1'b0;
				for (int i = 0; i < CW_W; i++) begin
					if ((i / GRP_W) == g && (((i + 1) >> k) & 1) == 1) begin
						par_d[k][g] = par_d[k][g] ^ src_word[i];
					end
				end
			end
		end
	end

	always_comb begin
		word_d = word_s2;
		for (int k = 0; k < NPAR; k++) begin
			word_d[CW_IW'((1 << k) - 1)] = ^par_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= src_ctl;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= src_word;
		par_s2  <= par_d;
		word_s3 <= word_d;
	end

	assign res_ctl  = ctl_s3;
	assign res_word = word_s3;

endmodule

`default_nettype wire

/* rtl/hamming_code_encoder.sv */
// Top level of the Hamming code encoder with even parity and a message-length register.
//
//  Channel     Signals                                        Handshake
//  ---------   --------------------------------------------   ------------------------------
//  input beat  message_bits                                   taken when start & !busy
//  result beat codeword, code_len, parity_count               shown for one cycle with done
//  config      cfg_wdata (msg_len)                            written when cfg_we is high
//
// Each beat passes the stages in turn from start to done: stage one clamps the
// message length, masks the message and scatters it onto the data positions,
// stage two forms partial parity sums and stage three folds them and inserts
// the parity bits. A new beat may enter in every cycle, so busy stays low.
// Reset clears the valid bits of all stages and sets msg_len to 57.
// The receiver cannot stall; each result is present for exactly one cycle.
`default_nettype none

module hamming_code_encoder
	import hce_pkg::*;
#(
	parameter int MAX_MSG_BITS = MAX_MSG_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [MSG_W-1:0]  message_bits,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	output logic              done,
	output logic [CW_W-1:0]   codeword,
	output logic [LEN_W-1:0]  code_len,
	output logic [PC_W-1:0]   parity_count
);

	logic [LEN_W-1:0] msg_len_q;
	logic [LEN_W-1:0] m_eff;
	logic [PC_W-1:0]  r_eff;
	logic [CW_W-1:0]  placed;
	logic [CW_W-1:0]  word_s1;
	hce_ctl_t         ctl_s1;
	hce_ctl_t         res_ctl;
	logic [NPAR-1:0]  syndrome;

	// The pipeline never holds off a beat.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= LEN_W'(MSG_LEN_RST);
		end else if (cfg_we) begin
			msg_len_q <= cfg_wdata;
		end
	end

	// A length of zero acts as one; a length above the maximum saturates.
	always_comb begin
		if (msg_len_q == '0) begin
			m_eff = LEN_W'(1);
		end else if (msg_len_q > LEN_W'(MAX_MSG_BITS)) begin
			m_eff = LEN_W'(MAX_MSG_BITS);
		end else begin
			m_eff = msg_len_q;
		end
	end

	// Smallest r with 2^r >= m + r + 1, written as thresholds on m.
	always_comb begin
		if (m_eff <= LEN_W'(1)) begin
			r_eff = PC_W'(2);
		end else if (m_eff <= LEN_W'(4)) begin
			r_eff = PC_W'(3);
		end else if (m_eff <= LEN_W'(11)) begin
			r_eff = PC_W'(4);
		end else if (m_eff <= LEN_W'(26)) begin
			r_eff = PC_W'(5);
		end else begin
			r_eff = PC_W'(6);
		end
	end

	// Message bit k always lands on the same data position, whatever the
	// length. Bits at or above the length are dropped here, which also keeps
	// every position beyond the codeword length at zero, so the parity sums
	// can run over the full word.
	always_comb begin
		placed = '0;
		for (int k = 0; k < MAX_MSG_BITS; k++) begin
			if (LEN_W'(k) < m_eff) begin
				placed[CW_IW'(data_pos(k))] = message_bits[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld          <= start & ~busy;
			ctl_s1.code_len     <= m_eff + LEN_W'(r_eff);
			ctl_s1.parity_count <= r_eff;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= placed;
	end

	hce_parity u_parity (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_ctl  (ctl_s1),
		.src_word (word_s1),
		.res_ctl  (res_ctl),
		.res_word (codeword)
	);

	assign done         = res_ctl.vld;
	assign code_len     = res_ctl.code_len;
	assign parity_count = res_ctl.parity_count;

	// Syndrome of the outgoing codeword; an even parity code gives all zeros.
	always_comb begin
		for (int k = 0; k < NPAR; k++) begin
			syndrome[k] = 1'b0;
			for (int i = 0; i < CW_W; i++) begin
				if ((((i + 1) >> k) & 1) == 1) begin
					syndrome[k] = syndrome[k] ^ codeword[i];
				end
			end
		end
	end

	// Each result follows a beat taken earlier, registered through ctl_s1, ctl_s2 and ctl_s3.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start & ~busy, 3))
		else $error("result without a beat taken three cycles earlier");

	// Nothing may be set beyond the codeword length.
	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((codeword >> code_len) == '0))
		else $error("codeword bits set at or above code_len");

	// Every parity check of the outgoing codeword is satisfied.
	a_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (syndrome == '0))
		else $error("codeword has a nonzero syndrome");

endmodule

`default_nettype wire

/* bench/hamming_code_encoder_tb.sv */
// Self-checking testbench for the Hamming code encoder, with directed and random beats.
`timescale 1ns / 1ps

module hamming_code_encoder_tb
	import hce_pkg::*;
();

	// One encoded word as the block should present it on its result ports.
	typedef struct packed {
		logic [CW_W-1:0]  cw;
		logic [LEN_W-1:0] n;
		logic [PC_W-1:0]  r;
	} encoded_word_t;

	// The slowest correct run stays well under this limit: 818 beats, each
	// with at most one random gap, plus the three-stage latency per drain.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 6;
	localparam int PHASE_BEATS   = 100;
	localparam int RANDOM_PHASES = 8;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [MSG_W-1:0]   message_bits;
	logic               cfg_we;
	logic [LEN_W-1:0]   cfg_wdata;
	logic               done;
	logic [CW_W-1:0]    codeword;
	logic [LEN_W-1:0]   code_len;
	logic [PC_W-1:0]    parity_count;

	// Our own copy of the message-length register, updated on every write.
	logic [LEN_W-1:0]   msg_len_copy;
	// Codewords that have been requested but not yet seen, oldest first.
	encoded_word_t      pending_codes[$];
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	// When set, the sender inserts random gaps between some beats.
	bit                 sender_gaps;

	hamming_code_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.message_bits (message_bits),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.codeword     (codeword),
		.code_len     (code_len),
		.parity_count (parity_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Computes the even-parity Hamming codeword for one message under the
	// given length register. The register value is clamped first: zero means
	// one message bit and anything beyond the maximum saturates to it.
	function automatic encoded_word_t hamming_encode(input logic [MSG_W-1:0] msg,
			input logic [LEN_W-1:0] len_reg);
		encoded_word_t res;
		int m;
		int r;
		int n;
		int next;
		int pos;
		int k;
		logic par;
		m = int'(len_reg);
		if (m < 1) begin
			m = 1;
		end
		if (m > MAX_MSG_BITS_DEF) begin
			m = MAX_MSG_BITS_DEF;
		end
		// Smallest r with 2^r >= m + r + 1.
		r = 1;
		while ((1 << r) < m + r + 1) begin
			r++;
		end
		n = m + r;
		res = '0;
		next = 0;
		// Message bits fill the positions that are not powers of two, in order.
		for (pos = 1; pos <= n; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				res.cw[pos-1] = msg[next];
				next++;
			end
		end
		// Parity bit k sits at position 2^k and covers every position with bit k set.
		for (k = 0; k < r; k++) begin
			par = 1'b0;
			for (pos = 1; pos <= n; pos++) begin
				if ((pos & (1 << k)) != 0) begin
					par = par ^ res.cw[pos-1];
				end
			end
			res.cw[(1 << k) - 1] = par;
		end
		res.n = LEN_W'(n);
		res.r = PC_W'(r);
		return res;
	endfunction

	function automatic logic [MSG_W-1:0] random_message();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return MSG_W'(1) << $urandom_range(0, MSG_W - 1);
			default: return raw[MSG_W-1:0];
		endcase
	endfunction

	// Sends one message beat. Inputs move on the falling edge; the beat is
	// taken at the first rising edge with busy low, and only then is the
	// expected codeword queued. Start is left high so back-to-back beats need
	// no extra assignment; whoever follows lowers it.
	task automatic send_message(input logic [MSG_W-1:0] msg);
		int gap;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			// The message lines carry junk while start is low; it must be ignored.
			repeat (gap) begin
				@(negedge clk);
				start = 1'b0;
				message_bits = random_message();
			end
		end
		@(negedge clk);
		start = 1'b1;
		message_bits = msg;
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
		pending_codes.insert(pending_codes.size(), hamming_encode(msg, msg_len_copy));
	endtask

	// Lowers start and waits until every queued codeword has come back, then
	// lets the pipeline settle.
	task automatic drain_encoder();
		@(negedge clk);
		start = 1'b0;
		while (pending_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the message-length register. Callers make sure the block is idle.
	task automatic write_msg_len(input logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = LEN_W'($urandom);
		msg_len_copy = value;
	endtask

	// Full-length words straight out of reset: the register should read 57.
	task automatic test_reset_length();
		send_message('0);
		send_message('1);
		send_message({(MSG_W + 1) / 2 {2'b01}});
		send_message({(MSG_W + 1) / 2 {2'b10}});
		send_message(MSG_W'(1));
		send_message(MSG_W'(1) << (MSG_W - 1));
		drain_encoder();
	endtask

	// Length extremes: zero behaves as one, values past the maximum saturate,
	// and lengths on the boundary where the parity count steps up.
	task automatic test_length_extremes();
		write_msg_len(LEN_W'(0));
		send_message('0);
		send_message(MSG_W'(1));
		send_message('1);
		drain_encoder();
		write_msg_len(LEN_W'(1));
		send_message(MSG_W'(1));
		send_message('1);
		drain_encoder();
		write_msg_len('1);
		send_message('1);
		send_message(random_message());
		drain_encoder();
		write_msg_len(LEN_W'(MAX_MSG_BITS_DEF + 1));
		send_message('1);
		drain_encoder();
		// Four message bits give the classic seven-bit code.
		write_msg_len(LEN_W'(4));
		send_message(MSG_W'(4'b1011));
		send_message('1);
		drain_encoder();
		// Twenty-six bits fill a 31-bit codeword exactly; twenty-seven need six parity bits.
		write_msg_len(LEN_W'(26));
		send_message('1);
		drain_encoder();
		write_msg_len(LEN_W'(27));
		send_message('1);
		drain_encoder();
	endtask

	// Random phases, each with its own length, mostly spread over the full
	// register range with the extremes drawn now and then. The last phase runs without
	// gaps so the pipeline sees a long stretch at full rate.
	task automatic test_random_words();
		int phase;
		int i;
		logic [LEN_W-1:0] len_pick;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0: len_pick = ($urandom_range(0, 1) == 0) ? LEN_W'(0) : '1;
				1: len_pick = LEN_W'(1);
				2: len_pick = LEN_W'(MAX_MSG_BITS_DEF);
				default: len_pick = LEN_W'($urandom_range(0, 63));
			endcase
			write_msg_len(len_pick);
			sender_gaps = (phase != RANDOM_PHASES - 1);
			for (i = 0; i < PHASE_BEATS; i++) begin
				send_message(random_message());
			end
			drain_encoder();
		end
	endtask

	// Each result beat is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		encoded_word_t exp_word;
		if (arst_n && done) begin
			if (pending_codes.size() == 0) begin
				$display("%0t: result beat with nothing expected, codeword %h", $time, codeword);
				mismatch_count++;
			end else begin
				exp_word = pending_codes.pop_front();
				if (codeword !== exp_word.cw) begin
					$display("%0t: codeword mismatch: expected %h, actual %h",
						$time, exp_word.cw, codeword);
					mismatch_count++;
				end
				if (code_len !== exp_word.n) begin
					$display("%0t: code_len mismatch: expected %0d, actual %0d",
						$time, exp_word.n, code_len);
					mismatch_count++;
				end
				if (parity_count !== exp_word.r) begin
					$display("%0t: parity_count mismatch: expected %0d, actual %0d",
						$time, exp_word.r, parity_count);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		// Every input is known from time zero, before reset is released on a falling edge.
		arst_n = 1'b0;
		start = 1'b0;
		message_bits = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		msg_len_copy = LEN_W'(MSG_LEN_RST);
		sender_gaps = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_length();
		test_length_extremes();
		test_random_words();

		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
